[hdl/flsl_pkg.sv]
// ----------------------------------------------------------------------------
// flsl_pkg
// shared types and constants of the flood limiter with strike ladder
// ----------------------------------------------------------------------------
package flsl_pkg;

  localparam int TIME_W     = 40;
  localparam int DL_W       = TIME_W + 1;
  localparam int LEFT_W     = 25;
  localparam int WIN_W      = 16;
  localparam int MAX_W      = 5;
  localparam int SEC_W      = 24;
  localparam int STRIKE_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int STAMP_CAP_DEF = 16;

  localparam logic [LEFT_W-1:0] YEAR_SECONDS = 25'd31536000;

  // verdict codes
  localparam logic [1:0] V_ALLOW  = 2'd0;
  localparam logic [1:0] V_MUTED  = 2'd1;
  localparam logic [1:0] V_STRIKE = 2'd2;
  localparam logic [1:0] V_BAN    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_WIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_FIRST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_SECOND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_LATER  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BAN_STRIKE  = 3'd6;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PRUNE,
    CELL_PUSH
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     keep;
    logic     full;
  } cell_ctl_t;

  typedef struct packed {
    logic [WIN_W-1:0]    window_seconds;
    logic [MAX_W-1:0]    max_in_window;
    logic [SEC_W-1:0]    decay_seconds;
    logic [SEC_W-1:0]    mute_first;
    logic [SEC_W-1:0]    mute_second;
    logic [SEC_W-1:0]    mute_later;
    logic [STRIKE_W-1:0] ban_strike;
  } cfg_t;

endpackage

[hdl/flsl_cell.sv]
// ----------------------------------------------------------------------------
// flsl_cell
// one stamp slot of the window row, fed by its right neighbor or the broadcast
// ----------------------------------------------------------------------------
module flsl_cell #(
  parameter int CAP = flsl_pkg::STAMP_CAP_DEF,
  parameter int IDX = 0,
  localparam int CW = $clog2(CAP + 1)
) (
  input  logic                         clk,
  input  flsl_pkg::cell_ctl_t          ctl,
  input  logic [CW-1:0]                len,
  input  logic [flsl_pkg::TIME_W-1:0]  right_val,
  input  logic [flsl_pkg::TIME_W-1:0]  bcast_val,
  output logic [flsl_pkg::TIME_W-1:0]  stamp
);

  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);
  localparam bit            IS_LAST  = (IDX == CAP - 1);

  logic [flsl_pkg::TIME_W-1:0] stamp_r;
  logic                        take_right;
  logic                        take_bcast;

  always_comb begin
    take_right = 1'b0;
    take_bcast = 1'b0;
    case (ctl.op)
      flsl_pkg::CELL_PRUNE: begin
        take_right = (NEXT_IDX < len);
        take_bcast = ctl.keep && (NEXT_IDX == len);
      end
      flsl_pkg::CELL_PUSH: begin
        take_right = ctl.full && !IS_LAST;
        take_bcast = ctl.full ? IS_LAST : (MY_IDX == len);
      end
      default: begin
        take_right = 1'b0;
        take_bcast = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take_bcast) begin
      stamp_r <= bcast_val;
    end else if (take_right) begin
      stamp_r <= right_val;
    end
  end

  assign stamp = stamp_r;

endmodule

[hdl/flsl_row.sv]
// ----------------------------------------------------------------------------
// flsl_row
// row of stamp cells, oldest stamp at the head
// ----------------------------------------------------------------------------
module flsl_row #(
  parameter int CAP = flsl_pkg::STAMP_CAP_DEF,
  localparam int CW = $clog2(CAP + 1)
) (
  input  logic                         clk,
  input  flsl_pkg::cell_ctl_t          ctl,
  input  logic [CW-1:0]                len,
  input  logic [flsl_pkg::TIME_W-1:0]  bcast_val,
  output logic [flsl_pkg::TIME_W-1:0]  head
);

  logic [flsl_pkg::TIME_W-1:0] stamp_q [CAP];

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [flsl_pkg::TIME_W-1:0] right_val;
    if (g < CAP - 1) begin : g_mid
      assign right_val = stamp_q[g + 1];
    end else begin : g_tail
      assign right_val = bcast_val;
    end
    flsl_cell #(
      .CAP (CAP),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .len       (len),
      .right_val (right_val),
      .bcast_val (bcast_val),
      .stamp     (stamp_q[g])
    );
  end

  assign head = stamp_q[0];

endmodule

[hdl/flsl_ctrl.sv]
// ----------------------------------------------------------------------------
// flsl_ctrl
// event sequencer: mute check, decay, prune walk, push and strike ladder
// ----------------------------------------------------------------------------
module flsl_ctrl #(
  parameter int CAP = flsl_pkg::STAMP_CAP_DEF,
  localparam int CW = $clog2(CAP + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [flsl_pkg::TIME_W-1:0]  in_now_seconds,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_verdict,
  output logic [flsl_pkg::LEFT_W-1:0]  out_mute_left,
  input  flsl_pkg::cfg_t               cfg,
  input  logic [flsl_pkg::TIME_W-1:0]  head,
  output flsl_pkg::cell_ctl_t          ctl,
  output logic [CW-1:0]                len,
  output logic [flsl_pkg::TIME_W-1:0]  bcast_val
);

  localparam int MW = (CW > flsl_pkg::MAX_W) ? CW : flsl_pkg::MAX_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DECAY,
    S_PRUNE,
    S_PUSH,
    S_SEND
  } state_t;

  state_t                          state_r;
  logic [flsl_pkg::TIME_W-1:0]     now_r;
  logic [flsl_pkg::TIME_W-1:0]     last_r;
  logic [flsl_pkg::DL_W-1:0]       dl_r;
  logic [flsl_pkg::DL_W-1:0]       quiet_r;
  logic [flsl_pkg::STRIKE_W-1:0]   strike_r;
  logic [CW-1:0]                   len_r;
  logic [CW-1:0]                   todo_r;
  logic [1:0]                      res_verdict_r;
  logic [flsl_pkg::LEFT_W-1:0]     res_left_r;
  logic                            out_valid_r;
  logic [1:0]                      out_verdict_r;
  logic [flsl_pkg::LEFT_W-1:0]     out_mute_left_r;

  logic [flsl_pkg::DL_W-1:0]       now_ext;
  logic                            muted;
  logic [flsl_pkg::DL_W-1:0]       mute_diff;
  logic [flsl_pkg::LEFT_W-1:0]     mute_sat;
  logic [flsl_pkg::DL_W-1:0]       quiet_nxt;
  logic [flsl_pkg::DL_W-1:0]       quiet_diff;
  logic                            decay_hit;
  logic [flsl_pkg::TIME_W-1:0]     age;
  logic                            keep;
  logic                            full;
  logic [CW-1:0]                   new_cnt;
  logic                            over;
  logic [flsl_pkg::STRIKE_W-1:0]   strike_inc;
  logic                            ban_hit;
  logic [flsl_pkg::SEC_W-1:0]      dur;
  logic [flsl_pkg::LEFT_W-1:0]     mute_len;
  logic [flsl_pkg::DL_W-1:0]       dl_new;
  logic                            out_free;

  always_comb begin
    now_ext    = {1'b0, now_r};
    muted      = dl_r > now_ext;
    mute_diff  = dl_r - now_ext;
    mute_sat   = (mute_diff > flsl_pkg::DL_W'(flsl_pkg::YEAR_SECONDS)) ?
                 flsl_pkg::YEAR_SECONDS : mute_diff[flsl_pkg::LEFT_W-1:0];
    quiet_nxt  = ({1'b0, last_r} > dl_r) ? {1'b0, last_r} : dl_r;
    quiet_diff = now_ext - quiet_r;
    decay_hit  = (strike_r != '0) && (quiet_r != '0) && (now_ext >= quiet_r) &&
                 (quiet_diff >= flsl_pkg::DL_W'(cfg.decay_seconds));
    age        = now_r - head;
    keep       = (head > now_r) || (age < flsl_pkg::TIME_W'(cfg.window_seconds));
    full       = (len_r == CAP_CNT);
    new_cnt    = full ? CAP_CNT : len_r + CW'(1);
    over       = MW'(new_cnt) > MW'(cfg.max_in_window);
    strike_inc = (strike_r < cfg.ban_strike) ? strike_r + 4'd1 : strike_r;
    ban_hit    = strike_inc >= cfg.ban_strike;
    case (strike_inc)
      4'd1:    dur = cfg.mute_first;
      4'd2:    dur = cfg.mute_second;
      default: dur = cfg.mute_later;
    endcase
    mute_len   = ban_hit ? flsl_pkg::YEAR_SECONDS : flsl_pkg::LEFT_W'(dur);
    dl_new     = now_ext + flsl_pkg::DL_W'(mute_len);
    out_free   = !out_valid_r || !out_stall;
  end

  // cell row control
  always_comb begin
    ctl.keep = keep;
    ctl.full = full;
    if (state_r == S_PRUNE && todo_r != '0) begin
      ctl.op = flsl_pkg::CELL_PRUNE;
    end else if (state_r == S_PUSH) begin
      ctl.op = flsl_pkg::CELL_PUSH;
    end else begin
      ctl.op = flsl_pkg::CELL_HOLD;
    end
    bcast_val = (ctl.op == flsl_pkg::CELL_PRUNE) ? head : now_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      dl_r        <= '0;
      strike_r    <= '0;
      len_r       <= '0;
      todo_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_SEND && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            now_r   <= in_now_seconds;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (muted) begin
            last_r        <= now_r;
            res_verdict_r <= flsl_pkg::V_MUTED;
            res_left_r    <= mute_sat;
            state_r       <= S_SEND;
          end else begin
            quiet_r <= quiet_nxt;
            state_r <= S_DECAY;
          end
        end
        S_DECAY: begin
          last_r <= now_r;
          if (decay_hit) begin
            strike_r <= '0;
            len_r    <= '0;
            dl_r     <= '0;
            todo_r   <= '0;
          end else begin
            todo_r <= len_r;
          end
          state_r <= S_PRUNE;
        end
        S_PRUNE: begin
          if (todo_r != '0) begin
            todo_r <= todo_r - CW'(1);
            if (!keep) begin
              len_r <= len_r - CW'(1);
            end
          end else begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (over) begin
            len_r         <= '0;
            strike_r      <= strike_inc;
            dl_r          <= dl_new;
            res_verdict_r <= ban_hit ? flsl_pkg::V_BAN : flsl_pkg::V_STRIKE;
            res_left_r    <= mute_len;
          end else begin
            len_r         <= new_cnt;
            res_verdict_r <= flsl_pkg::V_ALLOW;
            res_left_r    <= '0;
          end
          state_r <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            out_verdict_r   <= res_verdict_r;
            out_mute_left_r <= res_left_r;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_verdict   = out_verdict_r;
  assign out_mute_left = out_mute_left_r;
  assign len           = len_r;

`ifndef SYNTHESIS
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CAP_CNT)
    else $error("window count above capacity");

  a_todo_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PRUNE |-> todo_r <= len_r)
    else $error("prune walk longer than live window");

  a_ban_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_verdict_r == flsl_pkg::V_BAN |->
      out_mute_left_r == flsl_pkg::YEAR_SECONDS)
    else $error("ban without full year mute");

  a_allow_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_verdict_r == flsl_pkg::V_ALLOW |-> out_mute_left_r == '0)
    else $error("allow with mute time left");

  a_send_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEND && out_valid_r && out_stall |=> state_r == S_SEND)
    else $error("result dropped while output held");
`endif

endmodule

[hdl/flood_limiter_strike_ladder_top.sv]
// ----------------------------------------------------------------------------
// flood_limiter_strike_ladder_top
// sliding window message rate limiter with strike ladder and mute deadline
// ----------------------------------------------------------------------------
// usage:
//   in_valid / in_stall carry one message event (in_now_seconds) per transfer.
//   out_valid / out_stall carry one verdict and the mute seconds left per event.
//   cfg_valid / cfg_ready write one register by cfg_index; cfg_ready is
//   always high, write only while no event is in flight.
// sequence:
//   a muted event goes from the mute check straight to the send state.
//   any other event passes decay, the prune walk, push and send; the prune
//   walk moves one stamp per cycle through the cell row, over the stamps
//   held in the window after any decay (at most STAMP_CAP). The next event
//   is taken only once the last one has been sent.
// stall:
//   a stalled result holds in the output register while the next event is
//   taken and worked on; that event then waits until the register frees.
// reset:
//   synchronous rst_n restores the register defaults, empties the window and
//   clears strikes, mute deadline and last-seen time.
// ----------------------------------------------------------------------------
module flood_limiter_strike_ladder_top #(
  parameter int STAMP_CAP = flsl_pkg::STAMP_CAP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [flsl_pkg::TIME_W-1:0]      in_now_seconds,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_verdict,
  output logic [flsl_pkg::LEFT_W-1:0]      out_mute_left,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [flsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [flsl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(STAMP_CAP + 1);

  flsl_pkg::cfg_t              cfg_r;
  flsl_pkg::cell_ctl_t         ctl;
  logic [CW-1:0]               len;
  logic [flsl_pkg::TIME_W-1:0] bcast_val;
  logic [flsl_pkg::TIME_W-1:0] head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_seconds <= 16'd10;
      cfg_r.max_in_window  <= 5'd5;
      cfg_r.decay_seconds  <= 24'd120;
      cfg_r.mute_first     <= 24'd30;
      cfg_r.mute_second    <= 24'd120;
      cfg_r.mute_later     <= 24'd600;
      cfg_r.ban_strike     <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        flsl_pkg::CFG_WINDOW:      cfg_r.window_seconds <= cfg_data[flsl_pkg::WIN_W-1:0];
        flsl_pkg::CFG_MAX_IN_WIN:  cfg_r.max_in_window  <= cfg_data[flsl_pkg::MAX_W-1:0];
        flsl_pkg::CFG_DECAY:       cfg_r.decay_seconds  <= cfg_data;
        flsl_pkg::CFG_MUTE_FIRST:  cfg_r.mute_first     <= cfg_data;
        flsl_pkg::CFG_MUTE_SECOND: cfg_r.mute_second    <= cfg_data;
        flsl_pkg::CFG_MUTE_LATER:  cfg_r.mute_later     <= cfg_data;
        flsl_pkg::CFG_BAN_STRIKE:  cfg_r.ban_strike     <= cfg_data[flsl_pkg::STRIKE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  flsl_ctrl #(
    .CAP (STAMP_CAP)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_now_seconds (in_now_seconds),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_verdict    (out_verdict),
    .out_mute_left  (out_mute_left),
    .cfg            (cfg_r),
    .head           (head),
    .ctl            (ctl),
    .len            (len),
    .bcast_val      (bcast_val)
  );

  flsl_row #(
    .CAP (STAMP_CAP)
  ) u_row (
    .clk       (clk),
    .ctl       (ctl),
    .len       (len),
    .bcast_val (bcast_val),
    .head      (head)
  );

endmodule

[tb/sv/flsl_verdict_board_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsl_verdict_board_pkg
// scoreboard for the flood limiter, predicts each verdict and checks in order
// ----------------------------------------------------------------------------
package flsl_verdict_board_pkg;

  typedef struct packed {
    logic [1:0]                  verdict;
    logic [flsl_pkg::LEFT_W-1:0] secs_left;
  } limiter_verdict_t;

  class verdict_board;
    flsl_pkg::cfg_t                regs;
    logic [flsl_pkg::TIME_W-1:0]   window_stamps [flsl_pkg::STAMP_CAP_DEF];
    int                            stamp_count;
    logic [flsl_pkg::STRIKE_W-1:0] strikes;
    logic [flsl_pkg::DL_W-1:0]     deadline;
    logic [flsl_pkg::TIME_W-1:0]   seen_at;
    limiter_verdict_t              verdict_q [$];
    int                            failures;

    function new();
      regs.window_seconds = 16'd10;
      regs.max_in_window  = 5'd5;
      regs.decay_seconds  = 24'd120;
      regs.mute_first     = 24'd30;
      regs.mute_second    = 24'd120;
      regs.mute_later     = 24'd600;
      regs.ban_strike     = 4'd3;
      foreach (window_stamps[i]) window_stamps[i] = '0;
      stamp_count = 0;
      strikes     = '0;
      deadline    = '0;
      seen_at     = '0;
      failures    = 0;
    endfunction

    function void write_reg(logic [flsl_pkg::CFG_IDX_W-1:0] idx,
                            logic [flsl_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        flsl_pkg::CFG_WINDOW:      regs.window_seconds = data[flsl_pkg::WIN_W-1:0];
        flsl_pkg::CFG_MAX_IN_WIN:  regs.max_in_window  = data[flsl_pkg::MAX_W-1:0];
        flsl_pkg::CFG_DECAY:       regs.decay_seconds  = data[flsl_pkg::SEC_W-1:0];
        flsl_pkg::CFG_MUTE_FIRST:  regs.mute_first     = data[flsl_pkg::SEC_W-1:0];
        flsl_pkg::CFG_MUTE_SECOND: regs.mute_second    = data[flsl_pkg::SEC_W-1:0];
        flsl_pkg::CFG_MUTE_LATER:  regs.mute_later     = data[flsl_pkg::SEC_W-1:0];
        flsl_pkg::CFG_BAN_STRIKE:  regs.ban_strike     = data[flsl_pkg::STRIKE_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void note_event(logic [flsl_pkg::TIME_W-1:0] now);
      logic [flsl_pkg::DL_W-1:0]  now_ext;
      logic [flsl_pkg::DL_W-1:0]  quiet_start;
      logic [flsl_pkg::DL_W-1:0]  left;
      logic [flsl_pkg::SEC_W-1:0] dur;
      limiter_verdict_t           v;
      int                         kept;
      now_ext = {1'b0, now};

      // mute still running
      if (deadline > now_ext) begin
        seen_at     = now;
        left        = deadline - now_ext;
        v.verdict   = flsl_pkg::V_MUTED;
        v.secs_left = (left > flsl_pkg::YEAR_SECONDS) ?
                      flsl_pkg::YEAR_SECONDS : left[flsl_pkg::LEFT_W-1:0];
        verdict_q.push_back(v);
        return;
      end

      // strike decay after a quiet period
      quiet_start = (deadline > {1'b0, seen_at}) ? deadline : {1'b0, seen_at};
      if (strikes != 0 && quiet_start != 0 && now_ext >= quiet_start &&
          (now_ext - quiet_start) >= regs.decay_seconds) begin
        strikes     = '0;
        stamp_count = 0;
        deadline    = '0;
      end
      seen_at = now;

      // prune stale stamps, later stamps stay
      kept = 0;
      for (int i = 0; i < stamp_count; i++) begin
        if (window_stamps[i] > now ||
            (now - window_stamps[i]) < regs.window_seconds) begin
          window_stamps[kept] = window_stamps[i];
          kept++;
        end
      end
      stamp_count = kept;

      // drop oldest when full
      if (stamp_count >= flsl_pkg::STAMP_CAP_DEF) begin
        for (int i = 1; i < flsl_pkg::STAMP_CAP_DEF; i++) begin
          window_stamps[i-1] = window_stamps[i];
        end
        stamp_count = flsl_pkg::STAMP_CAP_DEF - 1;
      end
      window_stamps[stamp_count] = now;
      stamp_count++;

      if (stamp_count <= int'(regs.max_in_window)) begin
        v.verdict   = flsl_pkg::V_ALLOW;
        v.secs_left = '0;
        verdict_q.push_back(v);
        return;
      end

      stamp_count = 0;
      if (strikes < regs.ban_strike) strikes = strikes + 1'b1;
      if (strikes >= regs.ban_strike) begin
        deadline    = now_ext + flsl_pkg::YEAR_SECONDS;
        v.verdict   = flsl_pkg::V_BAN;
        v.secs_left = flsl_pkg::YEAR_SECONDS;
      end else begin
        case (strikes)
          4'd1:    dur = regs.mute_first;
          4'd2:    dur = regs.mute_second;
          default: dur = regs.mute_later;
        endcase
        deadline    = now_ext + dur;
        v.verdict   = flsl_pkg::V_STRIKE;
        v.secs_left = {1'b0, dur};
      end
      verdict_q.push_back(v);
    endfunction

    function void check_verdict(logic [1:0] verdict, logic [flsl_pkg::LEFT_W-1:0] got_left);
      limiter_verdict_t want;
      if (verdict_q.size() == 0) begin
        $error("verdict with no event waiting: verdict %0d out_mute_left %0d",
               verdict, got_left);
        failures++;
        return;
      end
      want = verdict_q.pop_front();
      if (verdict !== want.verdict) begin
        $error("verdict: expected %0d, actual %0d", want.verdict, verdict);
        failures++;
      end
      if (got_left !== want.secs_left) begin
        $error("out_mute_left: expected %0d, actual %0d", want.secs_left, got_left);
        failures++;
      end
    endfunction
  endclass

endpackage

[tb/sv/flood_limiter_strike_ladder_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flood_limiter_strike_ladder_top_tb
// directed ladder walk then random events under changing register settings,
// random idling on both sides and one long receiver hold-off
// ----------------------------------------------------------------------------
module flood_limiter_strike_ladder_top_tb;

  localparam int WATCHDOG_CYCLES  = 4000;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int EVENTS_PER_PHASE = 110;
  localparam logic [flsl_pkg::TIME_W-1:0] TIME_MAX = '1;

  logic                            clk            = 1'b0;
  logic                            rst_n          = 1'b0;
  logic                            in_valid       = 1'b0;
  logic                            in_stall;
  logic [flsl_pkg::TIME_W-1:0]     in_now_seconds = '0;
  logic                            out_valid;
  logic                            out_stall      = 1'b0;
  logic [1:0]                      out_verdict;
  logic [flsl_pkg::LEFT_W-1:0]     out_mute_left;
  logic                            cfg_valid      = 1'b0;
  logic                            cfg_ready;
  logic [flsl_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [flsl_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

  logic        idling_on = 1'b1;
  int          hold_reqs = 0;
  int unsigned cur_window = 10;
  int unsigned cur_decay  = 120;
  int unsigned cur_jump   = 721;
  int          idle_cycles = 0;

  flsl_verdict_board_pkg::verdict_board board = new();

  flood_limiter_strike_ladder_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_now_seconds (in_now_seconds),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_verdict    (out_verdict),
    .out_mute_left  (out_mute_left),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_verdict(out_verdict, out_mute_left);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("** flood_limiter_strike_ladder_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall bursts, plus the long hold-off on request
  initial begin : verdict_sink
    int hold_done;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_done) begin
        hold_done++;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_event(input logic [flsl_pkg::TIME_W-1:0] stamp);
    int gap;
    gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_now_seconds <= stamp;
    do @(posedge clk); while (in_stall);
    board.note_event(stamp);
  endtask

  task automatic wait_verdicts_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [flsl_pkg::CFG_IDX_W-1:0] idx,
                                input int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= flsl_pkg::CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, flsl_pkg::CFG_DATA_W'(data));
  endtask

  task automatic apply_settings(input int unsigned win, input int unsigned max_msgs,
                                input int unsigned decay, input int unsigned first,
                                input int unsigned second, input int unsigned later,
                                input int unsigned ban);
    int unsigned longest;
    write_register(flsl_pkg::CFG_WINDOW, win);
    write_register(flsl_pkg::CFG_MAX_IN_WIN, max_msgs);
    write_register(flsl_pkg::CFG_DECAY, decay);
    write_register(flsl_pkg::CFG_MUTE_FIRST, first);
    write_register(flsl_pkg::CFG_MUTE_SECOND, second);
    write_register(flsl_pkg::CFG_MUTE_LATER, later);
    write_register(flsl_pkg::CFG_BAN_STRIKE, ban);
    cfg_valid <= 1'b0;
    longest = (first > second) ? first : second;
    longest = (later > longest) ? later : longest;
    cur_window = win;
    cur_decay  = decay;
    cur_jump   = longest + decay + 1;
  endtask

  task automatic random_settings();
    int unsigned mute_top;
    mute_top = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 150;
    apply_settings($urandom_range(0, 40),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(9, 31) : $urandom_range(0, 8),
                   $urandom_range(0, 200),
                   $urandom_range(0, mute_top), $urandom_range(0, mute_top),
                   $urandom_range(0, mute_top), $urandom_range(0, 7));
  endtask

  // mostly dense bursts to reach strikes, with jumps past mutes and decay
  function automatic logic [flsl_pkg::TIME_W-1:0] next_stamp(
    input logic [flsl_pkg::TIME_W-1:0] stamp
  );
    int unsigned pick;
    logic [63:0] wide;
    pick = $urandom_range(0, 99);
    wide = {$urandom(), $urandom()};
    if (pick < 60) return stamp + $urandom_range(0, 2);
    if (pick < 72) return stamp + $urandom_range(0, cur_window + 2);
    if (pick < 82) return stamp + $urandom_range(0, cur_jump);
    if (pick < 87) return stamp + flsl_pkg::YEAR_SECONDS + $urandom_range(0, cur_decay + 5);
    if (pick < 94) return stamp - $urandom_range(1, 50);
    if (pick < 98) return wide[flsl_pkg::TIME_W-1:0];
    return '0;
  endfunction

  task automatic random_events(input int n, input bit with_hold,
                               inout logic [flsl_pkg::TIME_W-1:0] stamp);
    for (int k = 0; k < n; k++) begin
      if (with_hold && k == n / 4) hold_reqs <= hold_reqs + 1;
      stamp = next_stamp(stamp);
      send_event(stamp);
    end
  endtask

  initial begin : stimulus
    logic [flsl_pkg::TIME_W-1:0] stamp;
    stamp = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ladder under the reset settings: strike, muted, strike, ban, saturation, decay
    for (int k = 0; k <= 5; k++) send_event(flsl_pkg::TIME_W'(k));
    send_event(flsl_pkg::TIME_W'(10));
    for (int k = 40; k <= 45; k++) send_event(flsl_pkg::TIME_W'(k));
    send_event(flsl_pkg::TIME_W'(100));
    for (int k = 170; k <= 175; k++) send_event(flsl_pkg::TIME_W'(k));
    send_event(flsl_pkg::TIME_W'(170));
    send_event(flsl_pkg::TIME_W'(175 + flsl_pkg::YEAR_SECONDS + 200));
    send_event(TIME_MAX);
    send_event('0);
    wait_verdicts_drained();

    stamp = flsl_pkg::TIME_W'(1000);
    random_settings();
    random_events(EVENTS_PER_PHASE, 1'b1, stamp);
    wait_verdicts_drained();

    idling_on <= ($urandom_range(0, 3) != 0);
    apply_settings(16'hFFFF, 16, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 15);
    random_events(EVENTS_PER_PHASE, 1'b0, stamp);
    wait_verdicts_drained();

    idling_on <= ($urandom_range(0, 3) != 0);
    apply_settings(0, 1, 0, $urandom_range(0, 500), $urandom_range(0, 500),
                   $urandom_range(0, 500), 0);
    random_events(EVENTS_PER_PHASE, 1'b0, stamp);
    wait_verdicts_drained();

    for (int p = 0; p < 4; p++) begin
      idling_on <= ($urandom_range(0, 3) != 0);
      random_settings();
      random_events(EVENTS_PER_PHASE, 1'b0, stamp);
      wait_verdicts_drained();
    end

    // last part: no idling, low settings, ban close to the top of time
    idling_on <= 1'b0;
    apply_settings(1, 0, 1, 0, 0, 0, 1);
    random_events(EVENTS_PER_PHASE, 1'b0, stamp);
    send_event(TIME_MAX - 3);
    send_event(TIME_MAX);
    send_event(flsl_pkg::TIME_W'(5));
    wait_verdicts_drained();
    repeat (40) @(posedge clk);

    if (board.pending() != 0) $error("%0d verdicts never arrived", board.pending());
    if (board.failures == 0 && board.pending() == 0) begin
      $display("** flood_limiter_strike_ladder_top: PASSED **");
    end else begin
      $display("** flood_limiter_strike_ladder_top: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/flsl_pkg.sv
hdl/flsl_cell.sv
hdl/flsl_row.sv
hdl/flsl_ctrl.sv
hdl/flood_limiter_strike_ladder_top.sv
tb/sv/flsl_verdict_board_pkg.sv
tb/sv/flood_limiter_strike_ladder_top_tb.sv
